// ===== design/dsr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the line rasterizer.
package dsr_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MAX_THICK_DEF  = 16;

  // Configuration register widths and port shape
  localparam int CANVAS_W   = 11;
  localparam int THICK_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THICK_WIDTH   = 2'd2;

  // Reset values
  localparam logic [CANVAS_W-1:0] CANVAS_RESET = 11'd500;
  localparam logic [THICK_W-1:0]  THICK_RESET  = 5'd4;

  // Request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // Line styles
  localparam logic [2:0] STYLE_SOLID   = 3'd0;
  localparam logic [2:0] STYLE_DOTTED  = 3'd1;
  localparam logic [2:0] STYLE_DASHED  = 3'd2;
  localparam logic [2:0] STYLE_DASHDOT = 3'd3;
  localparam logic [2:0] STYLE_THICK   = 3'd4;

  // Pattern periods
  localparam int DOT_PERIOD  = 4;
  localparam int DASH_PERIOD = 6;
  localparam int DD_PERIOD   = 10;
  localparam int DD_ON       = 5;
  localparam int DD_EXTRA    = 7;
  localparam int DASH_CNT_W  = $clog2(DASH_PERIOD);
  localparam int DD_CNT_W    = $clog2(DD_PERIOD);

  // Controller to datapath commands
  typedef struct packed {
    logic load_line;
    logic load_step;
    logic div_step;
    logic next_beat;
    logic finish_step;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic beat_last;
  } stat_t;

endpackage

// ===== design/dsr_ctrl.sv =====
// Controller: sequences line set-up, the shared increment divider and output beats.
module dsr_ctrl import dsr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  req_type_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_START) begin
            cmd_o.load_line = 1'b1;
            cnt_d           = CNT_W'(FRAC_BITS);
            state_d         = ST_DIV;
          end else begin
            cmd_o.load_step = 1'b1;
            state_d         = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        // one quotient bit per cycle, MSB first
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          if (stat_i.beat_last) begin
            cmd_o.finish_step = 1'b1;
            state_d           = ST_IDLE;
          end else begin
            cmd_o.next_beat = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== design/dsr_datapath.sv =====
// Datapath: config registers, DDA position, restoring divider, pattern and span beat logic.
module dsr_datapath import dsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_THICK  = MAX_THICK_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  output stat_t                        stat_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  input  logic [2:0]                   line_style_i,
  output logic signed [COORD_BITS+1:0] pixel_x_o,
  output logic signed [COORD_BITS+1:0] pixel_y_o,
  output logic                         plot_o,
  output logic                         last_of_step_o,
  output logic                         line_done_o
);

  localparam int PIX_W = COORD_BITS + 2;
  localparam int POS_W = PIX_W + FRAC_BITS;
  localparam int Q_W   = FRAC_BITS + 1;
  localparam int REM_W = COORD_BITS + 1;
  localparam int IDX_W = COORD_BITS + 1;
  localparam int OFF_W = $clog2(MAX_THICK / 2 + 1) + 1;
  localparam int SAT_W = THICK_W + 1;
  localparam int CMP_W = (PIX_W > CANVAS_W) ? PIX_W : CANVAS_W;

  // Truncate position plus integer offset toward zero
  function automatic logic signed [PIX_W-1:0] pix_coord(input logic [POS_W-1:0] pos,
                                                        input logic signed [OFF_W-1:0] off);
    logic signed [PIX_W-1:0] s;
    s = $signed(pos[POS_W-1:FRAC_BITS]) + PIX_W'(off);
    if (s[PIX_W-1] && (pos[FRAC_BITS-1:0] != '0)) begin
      s = s + PIX_W'(1);
    end
    return s;
  endfunction

  // Configuration registers
  logic [CANVAS_W-1:0] cw_q, ch_q;
  logic [THICK_W-1:0]  thick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q    <= CANVAS_RESET;
      ch_q    <= CANVAS_RESET;
      thick_q <= THICK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANVAS_WIDTH:  cw_q    <= cfg_data_i[CANVAS_W-1:0];
        CFG_CANVAS_HEIGHT: ch_q    <= cfg_data_i[CANVAS_W-1:0];
        CFG_THICK_WIDTH:   thick_q <= cfg_data_i[THICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Start decode: deltas, magnitudes, length
  logic signed [COORD_BITS:0] dx_c, dy_c;
  logic [COORD_BITS-1:0]      adx_c, ady_c, len_c;

  assign dx_c  = $signed({1'b0, end_x_i}) - $signed({1'b0, start_x_i});
  assign dy_c  = $signed({1'b0, end_y_i}) - $signed({1'b0, start_y_i});
  assign adx_c = dx_c[COORD_BITS] ? COORD_BITS'(-dx_c) : dx_c[COORD_BITS-1:0];
  assign ady_c = dy_c[COORD_BITS] ? COORD_BITS'(-dy_c) : dy_c[COORD_BITS-1:0];
  assign len_c = (adx_c >= ady_c) ? adx_c : ady_c;

  // Line registers
  logic [POS_W-1:0]      pos_x_q, pos_y_q;
  logic [COORD_BITS-1:0] len_q;
  logic                  neg_x_q, neg_y_q, xmaj_q;
  logic [REM_W-1:0]      rem_x_q, rem_y_q;
  logic [Q_W-1:0]        q_x_q, q_y_q;
  logic [2:0]            style_q;

  // Divider step: both axes share the length divisor
  logic [REM_W-1:0] len_ext, diff_x, diff_y;
  logic             bit_x, bit_y;

  assign len_ext = {1'b0, len_q};
  assign bit_x   = (rem_x_q >= len_ext) && (len_q != '0);
  assign bit_y   = (rem_y_q >= len_ext) && (len_q != '0);
  assign diff_x  = bit_x ? rem_x_q - len_ext : rem_x_q;
  assign diff_y  = bit_y ? rem_y_q - len_ext : rem_y_q;

  // Signed increments
  logic [POS_W-1:0] inc_x, inc_y;

  assign inc_x = neg_x_q ? POS_W'(0) - POS_W'(q_x_q) : POS_W'(q_x_q);
  assign inc_y = neg_y_q ? POS_W'(0) - POS_W'(q_y_q) : POS_W'(q_y_q);

  // Step control state
  logic                  active_q;
  logic [IDX_W-1:0]      idx_q;
  logic [DASH_CNT_W-1:0] m6_q;
  logic [DD_CNT_W-1:0]   m10_q;
  logic                  out_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      pos_x_q <= POS_W'({start_x_i, {FRAC_BITS{1'b0}}});
      pos_y_q <= POS_W'({start_y_i, {FRAC_BITS{1'b0}}});
      len_q   <= len_c;
      neg_x_q <= dx_c[COORD_BITS];
      neg_y_q <= dy_c[COORD_BITS];
      xmaj_q  <= (adx_c > ady_c);
      rem_x_q <= REM_W'(adx_c);
      rem_y_q <= REM_W'(ady_c);
      style_q <= line_style_i;
    end else if (cmd_i.div_step) begin
      rem_x_q <= {diff_x[REM_W-2:0], 1'b0};
      rem_y_q <= {diff_y[REM_W-2:0], 1'b0};
      q_x_q   <= {q_x_q[Q_W-2:0], bit_x};
      q_y_q   <= {q_y_q[Q_W-2:0], bit_y};
    end else if (cmd_i.finish_step && active_q) begin
      pos_x_q <= pos_x_q + inc_x;
      pos_y_q <= pos_y_q + inc_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      m6_q     <= '0;
      m10_q    <= '0;
    end else if (cmd_i.load_line) begin
      active_q <= 1'b1;
      idx_q    <= '0;
      m6_q     <= '0;
      m10_q    <= '0;
    end else if (cmd_i.finish_step && active_q) begin
      idx_q <= idx_q + IDX_W'(1);
      m6_q  <= (m6_q == DASH_CNT_W'(DASH_PERIOD - 1)) ? '0 : m6_q + DASH_CNT_W'(1);
      m10_q <= (m10_q == DD_CNT_W'(DD_PERIOD - 1)) ? '0 : m10_q + DD_CNT_W'(1);
      if (out_done_q) begin
        active_q <= 1'b0;
      end
    end
  end

  // Thick span: saturated width, half span and offset walk
  logic [SAT_W-1:0]        thick_ext, w_sat;
  logic [OFF_W-1:0]        half_c;
  logic                    thick_on, span_on;
  logic signed [OFF_W-1:0] off_q, off_d, off_x, off_y;
  logic                    beat_last_c;

  assign thick_ext   = {1'b0, thick_q};
  assign w_sat       = (thick_ext > SAT_W'(MAX_THICK)) ? SAT_W'(MAX_THICK) : thick_ext;
  assign half_c      = OFF_W'(w_sat >> 1);
  assign thick_on    = (style_q == STYLE_THICK);
  assign span_on     = thick_on && (half_c != '0);
  assign off_d       = cmd_i.load_step ? (span_on ? OFF_W'(0) - half_c : '0)
                                       : off_q + OFF_W'(1);
  assign beat_last_c = span_on ? (off_d == half_c - OFF_W'(1)) : 1'b1;
  assign off_x       = xmaj_q ? '0 : off_d;
  assign off_y       = xmaj_q ? off_d : '0;

  // Pattern
  logic pat_on;

  always_comb begin
    case (style_q)
      STYLE_DOTTED:  pat_on = ((idx_q % IDX_W'(DOT_PERIOD)) == '0);
      STYLE_DASHED:  pat_on = (m6_q != '0);
      STYLE_DASHDOT: pat_on = (m10_q < DD_CNT_W'(DD_ON)) || (m10_q == DD_CNT_W'(DD_EXTRA));
      STYLE_THICK:   pat_on = span_on;
      default:       pat_on = 1'b1;
    endcase
  end

  // Candidate pixel and clip
  logic signed [PIX_W-1:0] px_c, py_c;
  logic                    inside_c, done_c;

  assign px_c     = pix_coord(pos_x_q, off_x);
  assign py_c     = pix_coord(pos_y_q, off_y);
  assign inside_c = !px_c[PIX_W-1] && !py_c[PIX_W-1]
                 && (CMP_W'($unsigned(px_c)) < CMP_W'(cw_q))
                 && (CMP_W'($unsigned(py_c)) < CMP_W'(ch_q));
  assign done_c   = (idx_q >= IDX_W'(len_q));

  // Output beat register
  logic signed [PIX_W-1:0] out_px_q, out_py_q;
  logic                    out_plot_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_step || cmd_i.next_beat) begin
      off_q <= off_d;
      if (!active_q) begin
        out_px_q   <= '0;
        out_py_q   <= '0;
        out_plot_q <= 1'b0;
        out_last_q <= 1'b1;
        out_done_q <= 1'b1;
      end else begin
        out_px_q   <= px_c;
        out_py_q   <= py_c;
        out_plot_q <= pat_on && inside_c;
        out_last_q <= beat_last_c;
        out_done_q <= done_c;
      end
    end
  end

  assign pixel_x_o        = out_px_q;
  assign pixel_y_o        = out_py_q;
  assign plot_o           = out_plot_q;
  assign last_of_step_o   = out_last_q;
  assign line_done_o      = out_done_q;
  assign stat_o.beat_last = out_last_q;

endmodule

// ===== design/dda_styled_line_rasterizer.sv =====
// Top level of the styled DDA line rasterizer: controller plus datapath.
// Start request: accepted, then run through the shared restoring divider
// (one quotient bit per cycle for both axes); no result beat.
// Step request: accepted, then result beats, each held until taken:
// 1 beat, or 2*(w/2) for a thick span with w capped at MAX_THICK and w/2 nonzero.
// Reset: canvas 500x500, thick width 4, no line active; no clearing pass.
module dda_styled_line_rasterizer import dsr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_THICK  = MAX_THICK_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic [COORD_BITS-1:0]        start_x_i,
  input  logic [COORD_BITS-1:0]        start_y_i,
  input  logic [COORD_BITS-1:0]        end_x_i,
  input  logic [COORD_BITS-1:0]        end_y_i,
  input  logic [2:0]                   line_style_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS+1:0] pixel_x_o,
  output logic signed [COORD_BITS+1:0] pixel_y_o,
  output logic                         plot_o,
  output logic                         last_of_step_o,
  output logic                         line_done_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller
  dsr_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath
  dsr_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .MAX_THICK  (MAX_THICK)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .line_style_i   (line_style_i),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .plot_o         (plot_o),
    .last_of_step_o (last_of_step_o),
    .line_done_o    (line_done_o)
  );

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result beat is pending");

  a_start_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_START)) |=> !out_valid_o)
    else $error("start request produced a result beat");

  a_step_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_STEP)) |=> out_valid_o)
    else $error("step request gave no result beat");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_step_o) |=> in_ready_o)
    else $error("block not ready after final beat of a step");

endmodule

// ===== dv/line_pixel_checker.sv =====
// Checker for the styled line rasterizer: predicts pixel beats per request and compares them.
module line_pixel_checker import dsr_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]            cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic                             req_type_i,
  input  logic [COORD_BITS_DEF-1:0]        start_x_i,
  input  logic [COORD_BITS_DEF-1:0]        start_y_i,
  input  logic [COORD_BITS_DEF-1:0]        end_x_i,
  input  logic [COORD_BITS_DEF-1:0]        end_y_i,
  input  logic [2:0]                       line_style_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [COORD_BITS_DEF+1:0] pixel_x_i,
  input  logic signed [COORD_BITS_DEF+1:0] pixel_y_i,
  input  logic                             plot_i,
  input  logic                             last_of_step_i,
  input  logic                             line_done_i,
  output int                               error_count_o,
  output int                               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [COORD_BITS_DEF+1:0] px;
    logic signed [COORD_BITS_DEF+1:0] py;
    logic                             plot;
    logic                             last;
    logic                             done;
  } pixel_beat_t;

  // Mirror of the configuration registers
  logic [CANVAS_W-1:0] canvas_w;
  logic [CANVAS_W-1:0] canvas_h;
  logic [THICK_W-1:0]  thick_w;

  // Mirror of the DDA state
  logic signed [27:0] pos_x;
  logic signed [27:0] pos_y;
  logic signed [17:0] inc_x;
  logic signed [17:0] inc_y;
  logic [10:0]        step_idx;
  logic [9:0]         line_len;
  logic [2:0]         style_q;
  logic               x_major;
  logic               line_active;

  pixel_beat_t expected_beats[$];
  int          errs = 0;

  // Fixed point to integer pixel, truncating toward zero
  function automatic longint fix_to_pixel(longint v);
    if (v >= 0) return v >>> FRAC;
    return -((-v) >>> FRAC);
  endfunction

  // Per-step increment (d << FRAC) / len, quotient truncated toward zero
  function automatic logic signed [17:0] fix_increment(longint d, longint len);
    longint q;
    if (len == 0) return '0;
    q = ((d < 0) ? -d : d) <<< FRAC;
    q = q / len;
    if (d < 0) q = -q;
    return q[17:0];
  endfunction

  function automatic bit style_on(logic [2:0] style, logic [10:0] i);
    case (style)
      STYLE_DOTTED:  return (i % DOT_PERIOD) == 0;
      STYLE_DASHED:  return (i % DASH_PERIOD) != 0;
      STYLE_DASHDOT: return (i % DD_PERIOD) < DD_ON || (i % DD_PERIOD) == DD_EXTRA;
      default:       return 1'b1;
    endcase
  endfunction

  // One candidate pixel, clipped against the canvas
  function automatic pixel_beat_t make_beat(longint px, longint py, bit on, bit last, bit done);
    pixel_beat_t b;
    bit in_canvas;
    in_canvas = px >= 0 && py >= 0 && px < longint'(canvas_w) && py < longint'(canvas_h);
    b.px   = px[COORD_BITS_DEF+1:0];
    b.py   = py[COORD_BITS_DEF+1:0];
    b.plot = on && in_canvas;
    b.last = last;
    b.done = done;
    return b;
  endfunction

  // Works out the beats one accepted request causes and updates the DDA state
  task automatic rasterise_req(logic req, logic [9:0] sx, logic [9:0] sy, logic [9:0] ex,
                               logic [9:0] ey, logic [2:0] style);
    longint x1, y1, dx, dy, adx, ady, len, half, shift, px, py;
    logic [THICK_W-1:0] w;
    bit done, on;
    if (req == REQ_START) begin
      x1 = sx;
      y1 = sy;
      dx = longint'(ex) - x1;
      dy = longint'(ey) - y1;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      len = (adx >= ady) ? adx : ady;
      pos_x = 28'(x1 <<< FRAC);
      pos_y = 28'(y1 <<< FRAC);
      inc_x = fix_increment(dx, len);
      inc_y = fix_increment(dy, len);
      line_len = len[9:0];
      step_idx = '0;
      style_q = style;
      x_major = adx > ady;
      line_active = 1'b1;
    end else if (!line_active) begin
      expected_beats.push_back(make_beat(0, 0, 1'b0, 1'b1, 1'b1));
    end else begin
      done = step_idx >= line_len;
      on = style_on(style_q, step_idx);
      if (style_q == STYLE_THICK) begin
        w = (thick_w > MAX_THICK_DEF) ? THICK_W'(MAX_THICK_DEF) : thick_w;
        half = w / 2;
        if (half == 0) begin
          // empty span: the position itself, never plotted
          expected_beats.push_back(make_beat(fix_to_pixel(pos_x), fix_to_pixel(pos_y),
                                             1'b0, 1'b1, done));
        end else begin
          // span across the minor axis
          for (longint off = -half; off < half; off++) begin
            shift = off * (longint'(1) <<< FRAC);
            px = x_major ? fix_to_pixel(pos_x) : fix_to_pixel(pos_x + shift);
            py = x_major ? fix_to_pixel(pos_y + shift) : fix_to_pixel(pos_y);
            expected_beats.push_back(make_beat(px, py, 1'b1, off == half - 1, done));
          end
        end
      end else begin
        expected_beats.push_back(make_beat(fix_to_pixel(pos_x), fix_to_pixel(pos_y),
                                           on, 1'b1, done));
      end
      pos_x = pos_x + inc_x;
      pos_y = pos_y + inc_y;
      step_idx = step_idx + 1'b1;
      if (done) line_active = 1'b0;
    end
  endtask

  // Register writes, result compare, then prediction of the new request
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_beat_t want;
    if (!rst_ni) begin
      canvas_w = CANVAS_RESET;
      canvas_h = CANVAS_RESET;
      thick_w = THICK_RESET;
      pos_x = '0;
      pos_y = '0;
      inc_x = '0;
      inc_y = '0;
      step_idx = '0;
      line_len = '0;
      style_q = STYLE_SOLID;
      x_major = 1'b0;
      line_active = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CANVAS_WIDTH:  canvas_w = cfg_data_i[CANVAS_W-1:0];
          CFG_CANVAS_HEIGHT: canvas_h = cfg_data_i[CANVAS_W-1:0];
          CFG_THICK_WIDTH:   thick_w = cfg_data_i[THICK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: pixel_x=%0d pixel_y=%0d",
                 pixel_x_i, pixel_y_i);
          errs++;
        end else begin
          want = expected_beats.pop_front();
          if (pixel_x_i !== want.px) begin
            $error("pixel_x: expected %0d, got %0d", want.px, pixel_x_i);
            errs++;
          end
          if (pixel_y_i !== want.py) begin
            $error("pixel_y: expected %0d, got %0d", want.py, pixel_y_i);
            errs++;
          end
          if (plot_i !== want.plot) begin
            $error("plot: expected %0b, got %0b", want.plot, plot_i);
            errs++;
          end
          if (last_of_step_i !== want.last) begin
            $error("last_of_step: expected %0b, got %0b", want.last, last_of_step_i);
            errs++;
          end
          if (line_done_i !== want.done) begin
            $error("line_done: expected %0b, got %0b", want.done, line_done_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        rasterise_req(req_type_i, start_x_i, start_y_i, end_x_i, end_y_i, line_style_i);
      end
    end
    error_count_o <= errs;
    pending_o <= expected_beats.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the line rasterizer testbench: clock, reset, request and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dsr_pkg::*;

  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * (FRAC_BITS_DEF + 1) + 8;
  localparam int ITEMS_PER_SET = 14;
  localparam int N_SETS        = 6;

  typedef enum logic [1:0] {MODE_RECV_SLOW, MODE_SEND_SLOW, MODE_NO_IDLE} idle_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]             cfg_idx_i = CFG_CANVAS_WIDTH;
  logic [CFG_DATA_W-1:0]            cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic                             req_type_i = REQ_STEP;
  logic [COORD_BITS_DEF-1:0]        start_x_i = '0;
  logic [COORD_BITS_DEF-1:0]        start_y_i = '0;
  logic [COORD_BITS_DEF-1:0]        end_x_i = '0;
  logic [COORD_BITS_DEF-1:0]        end_y_i = '0;
  logic [2:0]                       line_style_i = STYLE_SOLID;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [COORD_BITS_DEF+1:0] pixel_x_o;
  logic signed [COORD_BITS_DEF+1:0] pixel_y_o;
  logic                             plot_o;
  logic                             last_of_step_o;
  logic                             line_done_o;

  int         error_count;
  int         beats_pending;
  idle_mode_e mode = MODE_RECV_SLOW;
  int         items_sent = 0;

  // Register settings per phase: canvas width, canvas height, thick width
  int set_w[N_SETS] = '{1024, 0, 1, 640, 2047, 500};
  int set_h[N_SETS] = '{1024, 1, 0, 480, 1023, 500};
  int set_t[N_SETS] = '{16, 0, 1, 31, 3, 2};

  dda_styled_line_rasterizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_style_i  (line_style_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .plot_o        (plot_o),
    .last_of_step_o(last_of_step_o),
    .line_done_o   (line_done_o)
  );

  line_pixel_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .req_type_i    (req_type_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .line_style_i  (line_style_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_i     (pixel_x_o),
    .pixel_y_i     (pixel_y_o),
    .plot_i        (plot_o),
    .last_of_step_i(last_of_step_o),
    .line_done_i   (line_done_o),
    .error_count_o (error_count),
    .pending_o     (beats_pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #1ms;
    $display("FAIL dda_styled_line_rasterizer");
    $finish;
  end

  // Result side: random back-pressure, one long hold when idling stops
  initial begin
    int  hold_left;
    bit  hold_done;
    int  idle_pct;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      idle_pct = (mode == MODE_RECV_SLOW) ? 75 : ((mode == MODE_SEND_SLOW) ? 8 : 0);
      if (mode == MODE_NO_IDLE && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Offer one request beat, with random gaps before it, and wait for acceptance
  task automatic send_req(logic req, logic [9:0] sx, logic [9:0] sy, logic [9:0] ex,
                          logic [9:0] ey, logic [2:0] style);
    int idle_pct;
    idle_pct = (mode == MODE_SEND_SLOW) ? 75 : ((mode == MODE_RECV_SLOW) ? 8 : 0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    start_x_i    <= sx;
    start_y_i    <= sy;
    end_x_i      <= ex;
    end_y_i      <= ey;
    line_style_i <= style;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Step request; the endpoint and style fields carry junk
  task automatic send_step();
    send_req(REQ_STEP, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
             3'($urandom));
  endtask

  // A start followed by steps: short lines are walked to the end, long ones cut short
  task automatic random_line();
    logic [9:0] sx, sy, ex, ey;
    logic [2:0] style;
    int tx, ty, adx, ady, n_steps;
    sx = 10'($urandom);
    sy = 10'($urandom);
    if ($urandom_range(9) < 7) begin
      tx = int'(sx) + int'($urandom_range(24)) - 12;
      ty = int'(sy) + int'($urandom_range(24)) - 12;
      tx = (tx < 0) ? 0 : ((tx > 1023) ? 1023 : tx);
      ty = (ty < 0) ? 0 : ((ty > 1023) ? 1023 : ty);
      ex = tx[9:0];
      ey = ty[9:0];
      adx = (tx > int'(sx)) ? tx - int'(sx) : int'(sx) - tx;
      ady = (ty > int'(sy)) ? ty - int'(sy) : int'(sy) - ty;
      n_steps = ((adx > ady) ? adx : ady) + 1 + int'($urandom_range(3) == 0);
    end else begin
      ex = 10'($urandom);
      ey = 10'($urandom);
      n_steps = $urandom_range(8, 2);
    end
    style = ($urandom_range(3) == 0) ? STYLE_THICK : 3'($urandom_range(7));
    send_req(REQ_START, sx, sy, ex, ey, style);
    repeat (n_steps) send_step();
  endtask

  // Let every expected beat arrive, then cover a division still running
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(int w, int h, int t);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CANVAS_WIDTH;
    cfg_data_i <= CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CANVAS_HEIGHT;
    cfg_data_i <= CFG_DATA_W'(h);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_THICK_WIDTH;
    cfg_data_i <= CFG_DATA_W'(t);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int target;
    int pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset register values
    send_step();                                           // no line loaded
    send_req(REQ_START, 10'd0, 10'd0, 10'd0, 10'd0, STYLE_SOLID);   // zero length
    send_step();
    send_step();
    send_req(REQ_START, 10'd0, 10'd1023, 10'd1023, 10'd0, STYLE_DASHED);
    repeat (3) send_step();
    send_req(REQ_START, 10'd1023, 10'd0, 10'd1020, 10'd1, STYLE_THICK);  // span below zero
    repeat (2) send_step();
    send_req(REQ_START, 10'd5, 10'd5, 10'd5, 10'd9, STYLE_THICK);        // span across x
    send_step();
    send_req(REQ_START, 10'd10, 10'd20, 10'd14, 10'd24, STYLE_DASHDOT);  // diagonal
    repeat (5) send_step();
    send_req(REQ_START, 10'd100, 10'd100, 10'd96, 10'd93, STYLE_DOTTED);
    send_step();
    for (int s = 5; s < 8; s++) begin                                     // unused codes
      send_req(REQ_START, 10'd7, 10'd7, 10'd9, 10'd8, 3'(s));
      send_step();
    end
    wait_idle();

    // Random phases, one register setting each
    target = items_sent;
    for (int k = 0; k < N_SETS; k++) begin
      program_regs(set_w[k], set_h[k], set_t[k]);
      mode = (k < 2) ? MODE_RECV_SLOW : ((k < 4) ? MODE_SEND_SLOW : MODE_NO_IDLE);
      target += ITEMS_PER_SET;
      while (items_sent < target) begin
        pick = $urandom_range(9);
        if (pick == 0) begin
          send_step();
        end else if (pick == 1) begin
          // start abandoned before any step
          send_req(REQ_START, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                   3'($urandom));
        end else begin
          random_line();
        end
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("PASS dda_styled_line_rasterizer");
    end else begin
      $display("FAIL dda_styled_line_rasterizer");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dsr_pkg.sv
design/dsr_ctrl.sv
design/dsr_datapath.sv
design/dda_styled_line_rasterizer.sv
dv/line_pixel_checker.sv
dv/testbench.sv
